@@ rtl/iis_pkg.sv @@
// Shared constants, types and register indexes of the streaming integral image block.
package iis_pkg;

	localparam int MAX_WIDTH = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int SAMPLE_BITS = 16;

	localparam int SAMPLE_PORT_BITS = 16;
	localparam int SUM_BITS = 36;
	localparam int REG_BITS = 11;
	localparam int CFG_INDEX_BITS = 2;

	localparam int COL_BITS = $clog2(MAX_WIDTH);
	localparam int ROW_BITS = $clog2(MAX_HEIGHT);
	localparam int RUN_BITS = (SAMPLE_BITS + COL_BITS > SUM_BITS) ?
		SUM_BITS : SAMPLE_BITS + COL_BITS;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [CFG_INDEX_BITS-1:0] REG_WIDTH_IDX = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] REG_HEIGHT_IDX = CFG_INDEX_BITS'(1);
	localparam logic [REG_BITS-1:0] SIZE_RESET = REG_BITS'(16);

	typedef struct packed {
		logic [SAMPLE_BITS-1:0] sample;
		logic [COL_BITS-1:0] col;
		logic first_row;
		logic last_col;
		logic last_row;
	} iis_item_t;

endpackage

@@ rtl/iis_front.sv @@
// Front end: holds the frame size registers, tracks raster position and tags each request.
module iis_front import iis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [REG_BITS-1:0] cfg_data,
	input logic in_valid,
	input logic [SAMPLE_PORT_BITS-1:0] sample,
	input logic queue_full,
	output logic in_stall,
	output logic push,
	output iis_item_t push_item,
	output logic restart
);

	localparam int WDIM_BITS = COL_BITS + 1;
	localparam int HDIM_BITS = ROW_BITS + 1;
	localparam int CMP_BITS = 32;

	logic [REG_BITS-1:0] width_q;
	logic [REG_BITS-1:0] height_q;
	logic [COL_BITS-1:0] col_q;
	logic [ROW_BITS-1:0] row_q;
	logic [WDIM_BITS-1:0] w_eff;
	logic [HDIM_BITS-1:0] h_eff;
	logic last_col;
	logic last_row;

	// Zero acts as one, anything above the maximum acts as the maximum.
	always_comb begin
		if (width_q == '0) begin
			w_eff = WDIM_BITS'(1);
		end else if (CMP_BITS'(width_q) > CMP_BITS'(MAX_WIDTH)) begin
			w_eff = WDIM_BITS'(MAX_WIDTH);
		end else begin
			w_eff = WDIM_BITS'(width_q);
		end
		if (height_q == '0) begin
			h_eff = HDIM_BITS'(1);
		end else if (CMP_BITS'(height_q) > CMP_BITS'(MAX_HEIGHT)) begin
			h_eff = HDIM_BITS'(MAX_HEIGHT);
		end else begin
			h_eff = HDIM_BITS'(height_q);
		end
	end

	assign last_col = ({1'b0, col_q} + WDIM_BITS'(1)) == w_eff;
	assign last_row = ({1'b0, row_q} + HDIM_BITS'(1)) == h_eff;

	assign in_stall = queue_full;
	assign push = in_valid && !in_stall;
	assign restart = cfg_we && (cfg_index == REG_WIDTH_IDX || cfg_index == REG_HEIGHT_IDX);

	always_comb begin
		push_item.sample = sample[SAMPLE_BITS-1:0];
		push_item.col = col_q;
		push_item.first_row = (row_q == '0);
		push_item.last_col = last_col;
		push_item.last_row = last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= SIZE_RESET;
			height_q <= SIZE_RESET;
			col_q <= '0;
			row_q <= '0;
		end else if (restart) begin
			if (cfg_index == REG_WIDTH_IDX) begin
				width_q <= cfg_data;
			end else begin
				height_q <= cfg_data;
			end
			col_q <= '0;
			row_q <= '0;
		end else if (push) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_q + ROW_BITS'(1);
			end else begin
				col_q <= col_q + COL_BITS'(1);
			end
		end
	end

endmodule

@@ rtl/iis_queue.sv @@
// Short request queue between the front end and the accumulation back end.
module iis_queue import iis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic push,
	input iis_item_t push_item,
	input logic pop,
	output iis_item_t head,
	output logic empty,
	output logic full
);

	iis_item_t slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] count_q;

	assign empty = (count_q == '0);
	assign full = (count_q == QCNT_BITS'(QUEUE_DEPTH));
	assign head = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNT_BITS'(1);
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QUEUE_DEPTH))
		else $error("queue fill count above depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

endmodule

@@ rtl/iis_back.sv @@
// Back end: row running sum, line store of the previous row and the output register.
module iis_back import iis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic restart,
	input iis_item_t head,
	input logic empty,
	output logic pop,
	output logic out_valid,
	input logic out_stall,
	output logic [SUM_BITS-1:0] area_sum,
	output logic row_end,
	output logic frame_end
);

	logic [SUM_BITS-1:0] line_mem [MAX_WIDTH];
	logic [SUM_BITS-1:0] rd_data_s1;
	logic [RUN_BITS-1:0] run_q;
	logic [RUN_BITS-1:0] new_run;

	logic s1_valid_q;
	logic [COL_BITS-1:0] col_s1;
	logic first_row_s1;
	logic last_col_s1;
	logic last_row_s1;
	logic [RUN_BITS-1:0] run_s1;
	logic fwd_s1;
	logic [SUM_BITS-1:0] fwd_val_s1;

	logic s1_adv;
	logic [SUM_BITS-1:0] above;
	logic [SUM_BITS-1:0] total;

	logic out_valid_q;
	logic [SUM_BITS-1:0] sum_q;
	logic row_end_q;
	logic frame_end_q;

	assign s1_adv = s1_valid_q && (!out_valid_q || !out_stall);
	assign pop = !empty && (!s1_valid_q || s1_adv);
	assign new_run = run_q + RUN_BITS'(head.sample);

	// The entry of the item leaving s1 is written on the same edge that reads it for the
	// next item, so that one case is taken from a bypass register instead of the store.
	always_comb begin
		if (first_row_s1) begin
			above = '0;
		end else if (fwd_s1) begin
			above = fwd_val_s1;
		end else begin
			above = rd_data_s1;
		end
	end
	assign total = above + SUM_BITS'(run_s1);

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			line_mem[col_s1] <= total;
		end
		if (pop) begin
			rd_data_s1 <= line_mem[head.col];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			col_s1 <= head.col;
			first_row_s1 <= head.first_row;
			last_col_s1 <= head.last_col;
			last_row_s1 <= head.last_row;
			run_s1 <= new_run;
			fwd_s1 <= s1_adv && (col_s1 == head.col);
			fwd_val_s1 <= total;
		end
		if (s1_adv) begin
			sum_q <= total;
			row_end_q <= last_col_s1;
			frame_end_q <= last_col_s1 && last_row_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			s1_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				run_q <= '0;
			end else if (pop) begin
				run_q <= head.last_col ? '0 : new_run;
			end
			if (pop) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s1_adv) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign area_sum = sum_q;
	assign row_end = row_end_q;
	assign frame_end = frame_end_q;

	a_frame_closes_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && frame_end_q |-> row_end_q)
		else $error("frame end without row end");
	a_run_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		pop && head.last_col |=> run_q == '0)
		else $error("running sum not cleared at row end");
	a_s1_held: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q)
		else $error("stalled s1 item dropped");

endmodule

@@ rtl/integral_image_stream.sv @@
// Path: an accepted sample is pushed into the queue, popped into s1 and then registered at the output.
// Throughput: one sample per cycle while the output is not stalled; the line store has one write and one read a cycle.
// While output stalls, the four-entry queue, s1 and the output register hold up to six requests.
// Reset clears the raster position and running sum and sets both size registers to 16.
// The line store is not cleared; the first row of each frame ignores what it reads from it.
module integral_image_stream import iis_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_INDEX_BITS-1:0] cfg_index,
	input logic [REG_BITS-1:0] cfg_data,
	input logic in_valid,
	output logic in_stall,
	input logic [SAMPLE_PORT_BITS-1:0] sample,
	output logic out_valid,
	input logic out_stall,
	output logic [SUM_BITS-1:0] area_sum,
	output logic row_end,
	output logic frame_end
);

	logic push;
	iis_item_t push_item;
	logic restart;
	logic pop;
	iis_item_t head;
	logic empty;
	logic full;

	iis_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.sample(sample),
		.queue_full(full),
		.in_stall(in_stall),
		.push(push),
		.push_item(push_item),
		.restart(restart)
	);

	iis_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_item(push_item),
		.pop(pop),
		.head(head),
		.empty(empty),
		.full(full)
	);

	iis_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.restart(restart),
		.head(head),
		.empty(empty),
		.pop(pop),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.area_sum(area_sum),
		.row_end(row_end),
		.frame_end(frame_end)
	);

endmodule
